// ===== rtl/core/rbfk_pkg.sv =====
// Shared types, constants and tables for the RBF kernel element core.
// No dependencies; imported by every module of the block but rbfk_wmul.
`default_nettype none

package rbfk_pkg;

  localparam int DIMS          = 4;
  localparam int NUM_REGS      = 2 + DIMS;
  localparam int ADDR_W        = $clog2(NUM_REGS) + 2;
  localparam int IDX_W         = ADDR_W - 2;
  localparam int SUM_W         = 32 + $clog2(DIMS);
  localparam int EXP_TERMS     = 12;
  localparam int EXP_INT_LIMIT = 32;

  localparam logic [63:0] EINV_Q32 = 64'd1580030169;
  localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
  localparam logic [23:0] X_CLAMP  = 24'hFF_FFFF;

  localparam logic [31:0] MAG_RESET   = 32'h0100_0000;
  localparam logic [31:0] NOISE_RESET = 32'h0000_0000;
  localparam logic [31:0] INV_RESET   = 32'h0100_0000;

  // register map, one 32-bit word each
  localparam logic [IDX_W-1:0] REG_MAGNITUDE   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_NOISE_LEVEL = IDX_W'(1);
  localparam int               REG_INV_LENGTH  = 2;

  // pair modes
  localparam logic [1:0] MODE_CROSS = 2'd0;
  localparam logic [1:0] MODE_DIAG  = 2'd2;

  typedef logic [DIMS-1:0][31:0] word_vec_t;

  typedef struct packed {
    logic valid;
    logic diag;
    logic delta;
  } ctl_t;

  typedef struct packed {
    ctl_t      ctl;
    logic      big;
    logic [4:0]  ip;
    logic [15:0] f16;
    word_vec_t   sq;
  } exp_aux_t;

  // e^-i in Q.32 for the integer part, built by repeated truncating products
  typedef logic [32:0] eint_tbl_t [EXP_INT_LIMIT];

  function automatic eint_tbl_t gen_eint_tbl();
    eint_tbl_t   tbl;
    logic [63:0] p;
    p = 64'(ONE_Q32);
    for (int i = 0; i < EXP_INT_LIMIT; i++) begin
      tbl[i] = p[32:0];
      p = (p * EINV_Q32) >> 32;
    end
    return tbl;
  endfunction

  localparam eint_tbl_t EINT_TBL = gen_eint_tbl();

endpackage

`default_nettype wire

// ===== rtl/core/rbfk_wmul.sv =====
// Two-stage wide multiplier: four registered partial products, then a sum.
// Standalone; no package dependency.
`default_nettype none

module rbfk_wmul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic      [AW+BW-1:0] p
);

  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] pp_ll_r;
  logic [AL+BH-1:0] pp_lh_r;
  logic [AH+BL-1:0] pp_hl_r;
  logic [AH+BH-1:0] pp_hh_r;
  logic [PW-1:0]    p_r;
  logic [PW-1:0]    p_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= (AL+BL)'(a[AL-1:0])  * (AL+BL)'(b[BL-1:0]);
      pp_lh_r <= (AL+BH)'(a[AL-1:0])  * (AL+BH)'(b[BW-1:BL]);
      pp_hl_r <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
      pp_hh_r <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
      p_r     <= p_nxt;
    end
  end

  assign p_nxt = PW'(pp_ll_r) + (PW'(pp_lh_r) << BL) + (PW'(pp_hl_r) << AL)
               + (PW'(pp_hh_r) << (AL + BL));

  assign p = p_r;

endmodule

`default_nettype wire

// ===== rtl/core/rbfk_dist.sv =====
// Distance front end: differences, length scaling, squares and their sum.
// Depends on rbfk_pkg.
`default_nettype none

module rbfk_dist
  import rbfk_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      valid_i,
  input  wire logic [1:0] mode_i,
  input  wire word_vec_t left_i,
  input  wire word_vec_t right_i,
  input  wire word_vec_t inv_i,
  output exp_aux_t       aux_o
);

  logic [DIMS-1:0][32:0] diff;
  word_vec_t             ad_nxt;
  logic                  equal;
  ctl_t                  c1_nxt;

  word_vec_t             ad_r;
  ctl_t                  c1_r;
  logic [DIMS-1:0][63:0] prod_r;
  ctl_t                  c2_r;
  word_vec_t             sq_r;
  word_vec_t             sq_nxt;
  ctl_t                  c3_r;
  logic [SUM_W-1:0]      sum_nxt;
  exp_aux_t              aux_r;

  // S1: exact |l - r| on 33 bits
  always_comb begin
    equal = 1'b1;
    for (int j = 0; j < DIMS; j++) begin
      diff[j]   = {left_i[j][31], left_i[j]} - {right_i[j][31], right_i[j]};
      ad_nxt[j] = diff[j][32] ? 32'(~diff[j] + 33'd1) : diff[j][31:0];
      if (left_i[j] != right_i[j]) begin
        equal = 1'b0;
      end
    end
    c1_nxt.valid = valid_i;
    c1_nxt.diag  = (mode_i == MODE_DIAG);
    c1_nxt.delta = (mode_i == MODE_DIAG) || ((mode_i == MODE_CROSS) && equal);
  end

  // S3: clamp x to 24 bits and square
  always_comb begin
    logic [23:0] xq;
    logic [47:0] sqp;
    for (int j = 0; j < DIMS; j++) begin
      xq        = (|prod_r[j][63:48]) ? X_CLAMP : prod_r[j][47:24];
      sqp       = {24'd0, xq} * {24'd0, xq};
      sq_nxt[j] = sqp[47:16];
    end
  end

  // S4: sum of squares
  always_comb begin
    sum_nxt = '0;
    for (int j = 0; j < DIMS; j++) begin
      sum_nxt = sum_nxt + SUM_W'(sq_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r            <= '0;
      c2_r            <= '0;
      c3_r            <= '0;
      aux_r.ctl.valid <= 1'b0;
    end else if (en) begin
      c1_r <= c1_nxt;
      ad_r <= ad_nxt;
      c2_r <= c1_r;
      for (int j = 0; j < DIMS; j++) begin
        prod_r[j] <= {32'd0, ad_r[j]} * {32'd0, inv_i[j]};
      end
      c3_r      <= c2_r;
      sq_r      <= sq_nxt;
      aux_r.ctl <= c3_r;
      aux_r.sq  <= sq_r;
      aux_r.big <= |sum_nxt[SUM_W-1:22];
      aux_r.ip  <= sum_nxt[21:17];
      aux_r.f16 <= sum_nxt[16:1];
    end
  end

  assign aux_o = aux_r;

endmodule

`default_nettype wire

// ===== rtl/core/rbfk_exp_step.sv =====
// One Horner step of the e^-f series: multiply, then divide by the constant K.
// Depends on rbfk_pkg.
`default_nettype none

module rbfk_exp_step
  import rbfk_pkg::*;
#(
  parameter int K = 1
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire exp_aux_t    aux_i,
  input  wire logic [32:0] acc_i,
  output exp_aux_t         aux_o,
  output logic      [32:0] acc_o
);

  // floor(q/K) = floor(q*RECIP >> 33) or one more; q < 2^32
  localparam logic [33:0] RECIP = 34'((64'd1 << 33) / K);

  exp_aux_t    aux_a_r;
  logic [31:0] q_r;
  exp_aux_t    aux_b_r;
  logic [32:0] acc_r;

  logic [48:0] qprod;
  logic [65:0] rprod;
  logic [31:0] est;
  logic [35:0] rem;
  logic [31:0] est_fix;
  logic [32:0] acc_nxt;

  always_comb begin
    qprod   = {33'd0, aux_i.f16} * {16'd0, acc_i};
    rprod   = {34'd0, q_r} * {32'd0, RECIP};
    est     = rprod[64:33];
    rem     = {4'd0, q_r} - (36'(est) * 36'(K));
    est_fix = (rem >= 36'(K)) ? est + 32'd1 : est;
    acc_nxt = ONE_Q32 - {1'b0, est_fix};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aux_a_r.ctl.valid <= 1'b0;
      aux_b_r.ctl.valid <= 1'b0;
    end else if (en) begin
      aux_a_r <= aux_i;
      q_r     <= qprod[47:16];
      aux_b_r <= aux_a_r;
      acc_r   <= acc_nxt;
    end
  end

  assign aux_o = aux_b_r;
  assign acc_o = acc_r;

endmodule

`default_nettype wire

// ===== rtl/core/rbfk_exp.sv =====
// exp(-s/2) unit: Horner chain for the fraction, table for the integer part.
// Depends on rbfk_pkg, rbfk_exp_step.
`default_nettype none

module rbfk_exp
  import rbfk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire exp_aux_t    aux_i,
  output ctl_t             ctl_o,
  output word_vec_t        sq_o,
  output logic      [32:0] g_o
);

  exp_aux_t    aux_c [EXP_TERMS+1];
  logic [32:0] acc_c [EXP_TERMS+1];

  exp_aux_t    auxt_r;
  logic [32:0] acct_r;
  logic [32:0] pt_r;
  ctl_t        ctl_r;
  word_vec_t   sq_r;
  logic [32:0] g_r;
  logic [65:0] gprod;

  assign aux_c[0] = aux_i;
  assign acc_c[0] = ONE_Q32;

  for (genvar i = 0; i < EXP_TERMS; i++) begin : g_step
    rbfk_exp_step #(
      .K (EXP_TERMS - i)
    ) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .aux_i (aux_c[i]),
      .acc_i (acc_c[i]),
      .aux_o (aux_c[i+1]),
      .acc_o (acc_c[i+1])
    );
  end

  assign gprod = {33'd0, pt_r} * {33'd0, acct_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auxt_r.ctl.valid <= 1'b0;
      ctl_r            <= '0;
    end else if (en) begin
      auxt_r <= aux_c[EXP_TERMS];
      acct_r <= acc_c[EXP_TERMS];
      pt_r   <= EINT_TBL[aux_c[EXP_TERMS].ip];
      ctl_r  <= auxt_r.ctl;
      sq_r   <= auxt_r.sq;
      g_r    <= auxt_r.big ? 33'd0 : gprod[64:32];
    end
  end

  assign ctl_o = ctl_r;
  assign sq_o  = sq_r;
  assign g_o   = g_r;

endmodule

`default_nettype wire

// ===== rtl/core/rbfk_grad.sv =====
// Output stage: kernel value and gradients from g, with saturation to Q16.16.
// Depends on rbfk_pkg, rbfk_wmul.
`default_nettype none

module rbfk_grad
  import rbfk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire ctl_t        ctl_i,
  input  wire word_vec_t   sq_i,
  input  wire logic [32:0] g_i,
  input  wire logic [31:0] magnitude_i,
  input  wire word_vec_t   inv_i,
  input  wire logic [63:0] m2_i,
  input  wire logic [47:0] n2_i,
  input  wire logic [31:0] gn_i,
  output logic             valid_o,
  output logic      [31:0] kernel_o,
  output logic      [31:0] grad_mag_o,
  output word_vec_t        grad_len_o,
  output logic      [31:0] grad_noise_o
);

  logic [32:0]           geff_nxt;
  logic [48:0]           inner_nxt;
  logic [DIMS-1:0][63:0] ljp_nxt;

  ctl_t                  c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;
  logic [32:0]           geff_r;
  logic [48:0]           inner_r;
  logic [DIMS-1:0][63:0] ljp_r;
  logic [DIMS-1:0][39:0] lj2_r, lj3_r, lj4_r;
  logic [112:0]          kp;
  logic [80:0]           mp;
  logic [96:0]           mgp;
  logic [31:0]           kv4_r, kv5_r, kv6_r;
  logic [31:0]           gm4_r, gm5_r, gm6_r;
  logic [47:0]           mg4_r;
  logic [DIMS-1:0][87:0] glp;
  word_vec_t             gl_nxt;

  logic                  valid_r;
  logic                  diag7_r;
  logic [31:0]           kernel_r;
  logic [31:0]           grad_mag_r;
  word_vec_t             grad_len_r;
  logic [31:0]           grad_noise_r;

  // G1: diagonal forces g = 1, noise term added where delta holds
  always_comb begin
    geff_nxt  = ctl_i.diag ? ONE_Q32 : g_i;
    inner_nxt = 49'(geff_nxt) + (ctl_i.delta ? {1'b0, n2_i} : 49'd0);
    for (int j = 0; j < DIMS; j++) begin
      ljp_nxt[j] = {32'd0, sq_i[j]} * {32'd0, inv_i[j]};
    end
  end

  rbfk_wmul #(.AW(64), .BW(49)) u_kmul (
    .clk (clk), .en (en), .a (m2_i), .b (inner_r), .p (kp)
  );

  rbfk_wmul #(.AW(32), .BW(49)) u_mmul (
    .clk (clk), .en (en), .a (magnitude_i), .b (inner_r), .p (mp)
  );

  rbfk_wmul #(.AW(64), .BW(33)) u_mgmul (
    .clk (clk), .en (en), .a (m2_i), .b (geff_r), .p (mgp)
  );

  for (genvar j = 0; j < DIMS; j++) begin : g_len
    rbfk_wmul #(.AW(48), .BW(40)) u_glmul (
      .clk (clk), .en (en), .a (mg4_r), .b (lj4_r[j]), .p (glp[j])
    );
  end

  always_comb begin
    for (int j = 0; j < DIMS; j++) begin
      gl_nxt[j] = c6_r.diag ? 32'd0 :
                  ((|glp[j][87:64]) ? 32'hFFFF_FFFF : glp[j][63:32]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r    <= '0;
      c2_r    <= '0;
      c3_r    <= '0;
      c4_r    <= '0;
      c5_r    <= '0;
      c6_r    <= '0;
      valid_r <= 1'b0;
      diag7_r <= 1'b0;
    end else if (en) begin
      c1_r    <= ctl_i;
      geff_r  <= geff_nxt;
      inner_r <= inner_nxt;
      ljp_r   <= ljp_nxt;
      c2_r    <= c1_r;
      for (int j = 0; j < DIMS; j++) begin
        lj2_r[j] <= ljp_r[j][63:24];
      end
      c3_r  <= c2_r;
      lj3_r <= lj2_r;
      c4_r  <= c3_r;
      lj4_r <= lj3_r;
      kv4_r <= (|kp[112:96]) ? 32'hFFFF_FFFF : kp[95:64];
      gm4_r <= (|mp[80:71]) ? 32'hFFFF_FFFF : mp[70:39];
      mg4_r <= mgp[95:48];
      c5_r  <= c4_r;
      kv5_r <= kv4_r;
      gm5_r <= gm4_r;
      c6_r  <= c5_r;
      kv6_r <= kv5_r;
      gm6_r <= gm5_r;
      valid_r      <= c6_r.valid;
      diag7_r      <= c6_r.diag;
      kernel_r     <= kv6_r;
      grad_mag_r   <= gm6_r;
      grad_len_r   <= gl_nxt;
      grad_noise_r <= c6_r.diag ? gn_i : 32'd0;
    end
  end

  assign valid_o      = valid_r;
  assign kernel_o     = kernel_r;
  assign grad_mag_o   = grad_mag_r;
  assign grad_len_o   = grad_len_r;
  assign grad_noise_o = grad_noise_r;

  a_noise_off_diag: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !diag7_r |-> grad_noise_r == 32'd0)
    else $error("noise gradient nonzero off the diagonal");

  a_len_zero_diag: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && diag7_r |-> grad_len_r == '0)
    else $error("length gradient nonzero on the diagonal");

  a_valid_needs_en: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(valid_r) |-> $past(en))
    else $error("result valid rose while the pipeline was held");

endmodule

`default_nettype wire

// ===== rtl/core/rbf_kernel_element_with_gradient_core.sv =====
// Top level of the ARD squared-exponential kernel element core.
// Depends on rbfk_pkg, rbfk_dist, rbfk_exp, rbfk_grad, rbfk_wmul.
`default_nettype none

// Computes one Gaussian-process kernel element K = m^2*(exp(-s/2) + n^2*delta)
// and its gradients over magnitude, each length and noise, for one pair of
// 4-D points per item. Coordinates are signed Q16.16, registers unsigned
// Q8.24, results unsigned Q16.16 saturating at all ones. The core takes one
// item every clock while not stalled and passes it through the distance
// front end, the twelve-term Horner series of e^-f (one multiply stage and
// one divide-by-constant stage per term), the integer-part table and final
// product, and the gradient and saturation stages. A stall on the result
// side holds the whole pipeline, and in_stall rises only while a result is
// waiting in the output register. Registers are written over the APB-style
// port; writes should be made only while no item is in flight. Derived terms
// (m^2, n^2, 2m^2n) are registered after a write, 2m^2n last, as it is built from m^2.

module rbf_kernel_element_with_gradient_core
  import rbfk_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // item input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_mode,
  input  wire logic signed [31:0] in_left_coord_0,
  input  wire logic signed [31:0] in_left_coord_1,
  input  wire logic signed [31:0] in_left_coord_2,
  input  wire logic signed [31:0] in_left_coord_3,
  input  wire logic signed [31:0] in_right_coord_0,
  input  wire logic signed [31:0] in_right_coord_1,
  input  wire logic signed [31:0] in_right_coord_2,
  input  wire logic signed [31:0] in_right_coord_3,
  // result output
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             out_kernel_value,
  output logic [31:0]             out_grad_magnitude,
  output logic [31:0]             out_grad_length_0,
  output logic [31:0]             out_grad_length_1,
  output logic [31:0]             out_grad_length_2,
  output logic [31:0]             out_grad_length_3,
  output logic [31:0]             out_grad_noise,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // ---------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------
  logic [31:0]      mag_r;
  logic [31:0]      noise_r;
  word_vec_t        inv_r;
  logic             cfg_wr;
  logic [IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r   <= MAG_RESET;
      noise_r <= NOISE_RESET;
      for (int j = 0; j < DIMS; j++) begin
        inv_r[j] <= INV_RESET;
      end
    end else if (cfg_wr) begin
      if (cfg_idx == REG_MAGNITUDE) begin
        mag_r <= pwdata;
      end
      if (cfg_idx == REG_NOISE_LEVEL) begin
        noise_r <= pwdata;
      end
      // writes past the last length register fall through and are dropped
      for (int j = 0; j < DIMS; j++) begin
        if (cfg_idx == IDX_W'(REG_INV_LENGTH + j)) begin
          inv_r[j] <= pwdata;
        end
      end
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (cfg_idx == REG_MAGNITUDE) begin
      prdata = mag_r;
    end
    if (cfg_idx == REG_NOISE_LEVEL) begin
      prdata = noise_r;
    end
    for (int j = 0; j < DIMS; j++) begin
      if (cfg_idx == IDX_W'(REG_INV_LENGTH + j)) begin
        prdata = inv_r[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Terms that depend only on registers: m^2 (Q16.48), n^2 (Q16.32), 2m^2n (Q16.16)
  // ---------------------------------------------------------------------
  logic [63:0] m2_r;
  logic [47:0] n2_r;
  logic [63:0] nnp;
  logic [95:0] gnp;
  logic [31:0] gn_r;

  assign nnp = {32'd0, noise_r} * {32'd0, noise_r};

  rbfk_wmul #(.AW(64), .BW(32)) u_gnmul (
    .clk (clk), .en (1'b1), .a (m2_r), .b (noise_r), .p (gnp)
  );

  always_ff @(posedge clk) begin
    m2_r <= {32'd0, mag_r} * {32'd0, mag_r};
    n2_r <= nnp[63:16];
    gn_r <= (|gnp[95:87]) ? 32'hFFFF_FFFF : gnp[86:55];
  end

  // ---------------------------------------------------------------------
  // Pipeline: one shared advance for every stage, held by a waiting result
  // ---------------------------------------------------------------------
  logic      pipe_en;
  word_vec_t left_w;
  word_vec_t right_w;
  exp_aux_t  dist_aux;
  ctl_t      exp_ctl;
  word_vec_t exp_sq;
  logic [32:0] exp_g;
  word_vec_t grad_len;

  assign pipe_en  = !(out_valid && out_stall);
  assign in_stall = !pipe_en;

  assign left_w[0]  = in_left_coord_0;
  assign left_w[1]  = in_left_coord_1;
  assign left_w[2]  = in_left_coord_2;
  assign left_w[3]  = in_left_coord_3;
  assign right_w[0] = in_right_coord_0;
  assign right_w[1] = in_right_coord_1;
  assign right_w[2] = in_right_coord_2;
  assign right_w[3] = in_right_coord_3;

  rbfk_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .valid_i (in_valid),
    .mode_i  (in_mode),
    .left_i  (left_w),
    .right_i (right_w),
    .inv_i   (inv_r),
    .aux_o   (dist_aux)
  );

  rbfk_exp u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (pipe_en),
    .aux_i (dist_aux),
    .ctl_o (exp_ctl),
    .sq_o  (exp_sq),
    .g_o   (exp_g)
  );

  rbfk_grad u_grad (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (pipe_en),
    .ctl_i        (exp_ctl),
    .sq_i         (exp_sq),
    .g_i          (exp_g),
    .magnitude_i  (mag_r),
    .inv_i        (inv_r),
    .m2_i         (m2_r),
    .n2_i         (n2_r),
    .gn_i         (gn_r),
    .valid_o      (out_valid),
    .kernel_o     (out_kernel_value),
    .grad_mag_o   (out_grad_magnitude),
    .grad_len_o   (grad_len),
    .grad_noise_o (out_grad_noise)
  );

  assign out_grad_length_0 = grad_len[0];
  assign out_grad_length_1 = grad_len[1];
  assign out_grad_length_2 = grad_len[2];
  assign out_grad_length_3 = grad_len[3];

endmodule

`default_nettype wire
